@@ hdl/pol_pkg.sv @@
// pol_pkg: request/response item types and code constants for the
// positional ordered list. No dependencies.
`default_nettype none

package pol_pkg;

   localparam int unsigned POS_W = 7;
   localparam int unsigned VAL_W = 32;

   typedef enum logic [1:0] {
      KIND_GET    = 2'd0,
      KIND_LOCATE = 2'd1,
      KIND_INSERT = 2'd2,
      KIND_DELETE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_RANGE     = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      kind_type          kind;
      logic [POS_W-1:0]  position;
      logic [VAL_W-1:0]  value;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [VAL_W-1:0]  read_value;
      logic [POS_W-1:0]  found_position;
      logic [POS_W-1:0]  length;
   } rsp_type;

   typedef struct packed {
      logic link_we;
      logic elem_we;
   } store_wr_type;

endpackage

`default_nettype wire

@@ hdl/positional_ordered_list.sv @@
// positional_ordered_list: linked ordered list with header and free chain,
// walked one link per cycle. Depends on pol_pkg and pol_store.
//
// Usage:
//   req channel (req_valid, req_stall, req_item) carries one request item:
//   get, locate, insert or delete. rsp channel (rsp_valid, rsp_stall,
//   rsp_item) returns exactly one item per request with status and length.
//   One request is worked at a time; req_stall is high from acceptance
//   until the result is loaded into the output register.
//   From acceptance the block walks the chain one link step per cycle
//   through the link memory's registered read port. get walks to the
//   position and reads the element; insert and delete add a relinking
//   step; locate scans until a match or the end of the list; a range or
//   full error goes straight to the result. The next item is taken in the
//   cycle after the result is loaded, also while it still waits in the
//   output register.
//   Reset (synchronous) empties the list at once: unused link entries read
//   through a fill mark, so no clearing pass is needed. A stalled result
//   holds in the output register and the block finishes its current item
//   and waits.
`default_nettype none

module positional_ordered_list #(
   parameter int unsigned CAPACITY   = 64,
   parameter int unsigned DATA_WIDTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire pol_pkg::req_type req_item,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output pol_pkg::rsp_type      rsp_item
);

   localparam int unsigned AW   = $clog2(CAPACITY + 1);
   localparam int unsigned IW   = $clog2(CAPACITY);
   localparam int unsigned CW   = $clog2(CAPACITY + 2);
   localparam int unsigned CMPW = ((AW > pol_pkg::POS_W) ? AW : pol_pkg::POS_W) + 1;
   localparam logic [AW-1:0] HDR = AW'(CAPACITY);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_FETCH,
      ST_LINK,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type                    state_ff, state_in;
   logic [AW-1:0]                cur_ff, cur_in;
   logic [AW-1:0]                cnt_ff, cnt_in;
   logic [CW-1:0]                idx_ff, idx_in;
   logic [AW-1:0]                pred_ff, pred_in;
   logic [AW-1:0]                tmp_ff, tmp_in;
   logic [AW-1:0]                free_head_ff, free_head_in;
   logic [AW-1:0]                hdr_next_ff, hdr_next_in;
   logic [AW-1:0]                hwm_ff, hwm_in;
   logic [AW-1:0]                count_ff, count_in;
   pol_pkg::kind_type            kind_ff, kind_in;
   logic [DATA_WIDTH-1:0]        val_ff, val_in;
   pol_pkg::status_type          status_ff, status_in;
   logic [pol_pkg::VAL_W-1:0]    rd_ff, rd_in;
   logic [pol_pkg::POS_W-1:0]    found_ff, found_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   pol_pkg::rsp_type             rsp_item_ff, rsp_item_in;

   pol_pkg::store_wr_type        wr;
   logic [IW-1:0]                wr_addr;
   logic [AW-1:0]                link_wdata;
   logic [IW-1:0]                rd_addr;
   logic [AW-1:0]                link_q;
   logic [DATA_WIDTH-1:0]        elem_q;
   logic [AW-1:0]                nxt;
   logic [CMPW-1:0]              pos_ext;
   logic [CMPW-1:0]              cnt_ext;
   logic [63:0]                  val_wide;
   logic [63:0]                  elem_wide;

   pol_store #(
      .DEPTH      (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH),
      .AW         (AW),
      .IW         (IW)
   ) u_store (
      .clock      (clock),
      .wr         (wr),
      .wr_addr    (wr_addr),
      .link_wdata (link_wdata),
      .elem_wdata (val_ff),
      .rd_addr    (rd_addr),
      .link_q     (link_q),
      .elem_q     (elem_q)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign pos_ext   = CMPW'(req_item.position);
   assign cnt_ext   = CMPW'(count_ff);
   assign val_wide  = 64'(req_item.value);
   assign elem_wide = 64'(elem_q);
   assign rd_addr   = (cur_in < HDR) ? cur_in[IW-1:0] : '0;

   always_comb begin
      if (cur_ff == HDR) begin
         nxt = hdr_next_ff;
      end else if (cur_ff >= hwm_ff) begin
         nxt = cur_ff + AW'(1);
      end else begin
         nxt = link_q;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      pred_in      = pred_ff;
      tmp_in       = tmp_ff;
      free_head_in = free_head_ff;
      hdr_next_in  = hdr_next_ff;
      hwm_in       = hwm_ff;
      count_in     = count_ff;
      kind_in      = kind_ff;
      val_in       = val_ff;
      status_in    = status_ff;
      rd_in        = rd_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      wr           = '0;
      wr_addr      = cur_ff[IW-1:0];
      link_wdata   = tmp_ff;

      case (state_ff)
         ST_IDLE: begin
            cur_in = HDR;
            if (req_valid) begin
               kind_in   = req_item.kind;
               val_in    = val_wide[DATA_WIDTH-1:0];
               status_in = pol_pkg::STATUS_OK;
               rd_in     = '0;
               found_in  = '0;
               cnt_in    = '0;
               state_in  = ST_WALK;
               case (req_item.kind)
                  pol_pkg::KIND_GET, pol_pkg::KIND_DELETE: begin
                     if (pos_ext == '0 || pos_ext > cnt_ext) begin
                        status_in = pol_pkg::STATUS_RANGE;
                        state_in  = ST_DONE;
                     end else begin
                        cnt_in = AW'(pos_ext - CMPW'(1));
                     end
                  end
                  pol_pkg::KIND_INSERT: begin
                     if (count_ff >= HDR || free_head_ff >= HDR) begin
                        status_in = pol_pkg::STATUS_FULL;
                        state_in  = ST_DONE;
                     end else if (pos_ext == '0 || pos_ext > cnt_ext + CMPW'(1)) begin
                        status_in = pol_pkg::STATUS_RANGE;
                        state_in  = ST_DONE;
                     end else begin
                        cnt_in = AW'(pos_ext - CMPW'(1));
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_WALK: begin
            if (cnt_ff != '0) begin
               cur_in = nxt;
               cnt_in = cnt_ff - AW'(1);
            end else begin
               case (kind_ff)
                  pol_pkg::KIND_LOCATE: begin
                     cur_in   = nxt;
                     idx_in   = CW'(1);
                     state_in = ST_SCAN;
                  end
                  pol_pkg::KIND_INSERT: begin
                     pred_in  = cur_ff;
                     tmp_in   = nxt;
                     cur_in   = free_head_ff;
                     state_in = ST_FETCH;
                  end
                  default: begin
                     pred_in  = cur_ff;
                     cur_in   = nxt;
                     state_in = ST_FETCH;
                  end
               endcase
            end
         end

         ST_FETCH: begin
            case (kind_ff)
               pol_pkg::KIND_INSERT: begin
                  wr.link_we   = 1'b1;
                  wr.elem_we   = 1'b1;
                  link_wdata   = tmp_ff;
                  free_head_in = nxt;
                  tmp_in       = cur_ff;
                  count_in     = count_ff + AW'(1);
                  if (cur_ff == hwm_ff) begin
                     hwm_in = hwm_ff + AW'(1);
                  end
                  state_in = ST_LINK;
               end
               pol_pkg::KIND_DELETE: begin
                  wr.link_we   = 1'b1;
                  link_wdata   = free_head_ff;
                  free_head_in = cur_ff;
                  tmp_in       = nxt;
                  rd_in        = elem_wide[pol_pkg::VAL_W-1:0];
                  count_in     = count_ff - AW'(1);
                  state_in     = ST_LINK;
               end
               default: begin
                  rd_in    = elem_wide[pol_pkg::VAL_W-1:0];
                  state_in = ST_DONE;
               end
            endcase
         end

         ST_LINK: begin
            wr_addr = pred_ff[IW-1:0];
            if (pred_ff == HDR) begin
               hdr_next_in = tmp_ff;
            end else begin
               wr.link_we = 1'b1;
            end
            state_in = ST_DONE;
         end

         ST_SCAN: begin
            if (cur_ff == HDR || CMPW'(idx_ff) > cnt_ext) begin
               status_in = pol_pkg::STATUS_NOT_FOUND;
               found_in  = '0;
               state_in  = ST_DONE;
            end else if (elem_q == val_ff) begin
               found_in = pol_pkg::POS_W'(idx_ff);
               state_in = ST_DONE;
            end else begin
               cur_in = nxt;
               idx_in = idx_ff + CW'(1);
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                = 1'b1;
               rsp_item_in.status          = status_ff;
               rsp_item_in.read_value      = rd_ff;
               rsp_item_in.found_position  = found_ff;
               rsp_item_in.length          = pol_pkg::POS_W'(count_ff);
               state_in                    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_head_ff <= '0;
         hdr_next_ff  <= HDR;
         hwm_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         hdr_next_ff  <= hdr_next_in;
         hwm_ff       <= hwm_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      pred_ff     <= pred_in;
      tmp_ff      <= tmp_in;
      kind_ff     <= kind_in;
      val_ff      <= val_in;
      status_ff   <= status_in;
      rd_ff       <= rd_in;
      found_ff    <= found_in;
      rsp_item_ff <= rsp_item_in;
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= HDR)
      else $error("element count above capacity");

   a_count_fill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= hwm_ff)
      else $error("element count above fill mark");

   a_count_change: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> ($past(state_ff) == ST_FETCH))
      else $error("element count changed outside fetch step");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("accepted item did not start work");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.status != pol_pkg::STATUS_OK) |->
      (rsp_item_ff.read_value == '0 && rsp_item_ff.found_position == '0))
      else $error("failed result carries data");
`endif

endmodule

`default_nettype wire

@@ hdl/pol_store.sv @@
// pol_store: element and link memories of the ordered list, one write
// port and one registered read port each. Depends on pol_pkg.
`default_nettype none

module pol_store #(
   parameter int unsigned DEPTH      = 64,
   parameter int unsigned DATA_WIDTH = 32,
   parameter int unsigned AW         = $clog2(DEPTH + 1),
   parameter int unsigned IW         = $clog2(DEPTH)
) (
   input  wire logic                     clock,
   input  wire pol_pkg::store_wr_type    wr,
   input  wire logic [IW-1:0]            wr_addr,
   input  wire logic [AW-1:0]            link_wdata,
   input  wire logic [DATA_WIDTH-1:0]    elem_wdata,
   input  wire logic [IW-1:0]            rd_addr,
   output logic      [AW-1:0]            link_q,
   output logic      [DATA_WIDTH-1:0]    elem_q
);

   logic [AW-1:0]         link_mem [DEPTH];
   logic [DATA_WIDTH-1:0] elem_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr.link_we) begin
         link_mem[wr_addr] <= link_wdata;
      end
      link_q <= link_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.elem_we) begin
         elem_mem[wr_addr] <= elem_wdata;
      end
      elem_q <= elem_mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// tb_top: checks the positional ordered list (get, locate, insert, delete) item by
// item against a queue-based model of the list, with random gaps and stalls.
// Depends on pol_pkg and positional_ordered_list.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LIST_CAP     = 64;
   localparam int unsigned LIMIT_CYCLES = 1_000_000;
   localparam int unsigned MAX_REPORTS  = 10;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   pol_pkg::req_type req_item  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   pol_pkg::rsp_type rsp_item;

   logic [pol_pkg::VAL_W-1:0] list_elems[$];
   pol_pkg::rsp_type          op_results_q[$];
   int unsigned               fail_count  = 0;
   int unsigned               cycle_count = 0;
   int unsigned               rsp_hold    = 0;
   bit                        quiet       = 1'b0;

   positional_ordered_list #(
      .CAPACITY   (LIST_CAP),
      .DATA_WIDTH (pol_pkg::VAL_W)
   ) uut (
      clock,
      reset,
      req_valid,
      req_stall,
      req_item,
      rsp_valid,
      rsp_stall,
      rsp_item
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Apply one list operation and return the result it yields.
   function automatic pol_pkg::rsp_type apply_list_op(pol_pkg::req_type it);
      pol_pkg::rsp_type r;
      int unsigned      n;
      int unsigned      p;
      r = '0;
      r.status = pol_pkg::STATUS_OK;
      n = list_elems.size();
      p = it.position;
      case (it.kind)
         pol_pkg::KIND_GET: begin
            if (p < 1 || p > n) r.status = pol_pkg::STATUS_RANGE;
            else r.read_value = list_elems[p-1];
         end
         pol_pkg::KIND_LOCATE: begin
            r.status = pol_pkg::STATUS_NOT_FOUND;
            for (int i = 0; i < n; i++) begin
               if (list_elems[i] == it.value) begin
                  r.found_position = pol_pkg::POS_W'(i + 1);
                  r.status = pol_pkg::STATUS_OK;
                  break;
               end
            end
         end
         pol_pkg::KIND_INSERT: begin
            if (n >= LIST_CAP) r.status = pol_pkg::STATUS_FULL;
            else if (p < 1 || p > n + 1) r.status = pol_pkg::STATUS_RANGE;
            else list_elems.insert(p - 1, it.value);
         end
         default: begin
            if (p < 1 || p > n) begin
               r.status = pol_pkg::STATUS_RANGE;
            end else begin
               r.read_value = list_elems[p-1];
               list_elems.delete(p - 1);
            end
         end
      endcase
      r.length = pol_pkg::POS_W'(list_elems.size());
      return r;
   endfunction

   always @(posedge clock) begin : check_rsp
      pol_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_hold = quiet ? 0 : $urandom_range(0, 4);
         if (op_results_q.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("unexpected item: status %0d read %h found %0d length %0d",
                        rsp_item.status, rsp_item.read_value,
                        rsp_item.found_position, rsp_item.length);
         end else begin
            want = op_results_q.pop_front();
            if (rsp_item.status !== want.status || rsp_item.read_value !== want.read_value
                || rsp_item.found_position !== want.found_position
                || rsp_item.length !== want.length) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("mismatch: expected %0d/%h/%0d/%0d got %0d/%h/%0d/%0d",
                           want.status, want.read_value, want.found_position,
                           want.length, rsp_item.status, rsp_item.read_value,
                           rsp_item.found_position, rsp_item.length);
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= (rsp_hold > 0);
      if (rsp_hold > 0) rsp_hold--;
   end

   task automatic send_item(input pol_pkg::kind_type kind, input int unsigned pos,
                            input logic [pol_pkg::VAL_W-1:0] val);
      pol_pkg::req_type it;
      int unsigned      gap;
      it.kind     = kind;
      it.position = pos[pol_pkg::POS_W-1:0];
      it.value    = val;
      gap = quiet ? 0 : $urandom_range(0, 4);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_item  <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      op_results_q.push_back(apply_list_op(it));
   endtask

   // Hold off new items until every result is back.
   task automatic drain_list_ops();
      @(negedge clock);
      req_valid <= 1'b0;
      while (op_results_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_list();
      send_item(pol_pkg::KIND_GET, 0, 32'h0);
      send_item(pol_pkg::KIND_GET, 1, $urandom);
      send_item(pol_pkg::KIND_LOCATE, 0, 32'h0);
      send_item(pol_pkg::KIND_DELETE, 1, 32'h0);
      send_item(pol_pkg::KIND_INSERT, 0, 32'h1);
      send_item(pol_pkg::KIND_INSERT, 2, 32'h2);
      send_item(pol_pkg::KIND_DELETE, 127, 32'h0);
   endtask

   task automatic test_edit_sequence();
      send_item(pol_pkg::KIND_INSERT, 1, 32'h0000_0000);
      send_item(pol_pkg::KIND_INSERT, 2, 32'hFFFF_FFFF);
      send_item(pol_pkg::KIND_INSERT, 1, 32'h5A5A_5A5A);
      send_item(pol_pkg::KIND_INSERT, 2, 32'hA5A5_A5A5);
      send_item(pol_pkg::KIND_INSERT, 5, 32'h0000_0000);
      send_item(pol_pkg::KIND_INSERT, 7, 32'h1234_5678);
      send_item(pol_pkg::KIND_GET, 1, 32'h0);
      send_item(pol_pkg::KIND_GET, 5, 32'h0);
      send_item(pol_pkg::KIND_GET, 6, 32'h0);
      send_item(pol_pkg::KIND_GET, 127, 32'h0);
      send_item(pol_pkg::KIND_LOCATE, 0, 32'h0000_0000);
      send_item(pol_pkg::KIND_LOCATE, 0, 32'hFFFF_FFFF);
      send_item(pol_pkg::KIND_LOCATE, 0, 32'h1234_5678);
      send_item(pol_pkg::KIND_DELETE, 3, 32'h0);
      send_item(pol_pkg::KIND_DELETE, 0, 32'h0);
      send_item(pol_pkg::KIND_DELETE, 4, 32'h0);
   endtask

   task automatic test_full_list();
      drain_list_ops();
      while (list_elems.size() < LIST_CAP)
         send_item(pol_pkg::KIND_INSERT, $urandom_range(1, list_elems.size() + 1),
                   $urandom);
      send_item(pol_pkg::KIND_INSERT, 127, $urandom);
      send_item(pol_pkg::KIND_INSERT, 1, $urandom);
      send_item(pol_pkg::KIND_INSERT, 0, $urandom);
      send_item(pol_pkg::KIND_GET, LIST_CAP, 32'h0);
      send_item(pol_pkg::KIND_LOCATE, 0, list_elems[LIST_CAP-1]);
      send_item(pol_pkg::KIND_LOCATE, 0, $urandom);
      send_item(pol_pkg::KIND_DELETE, LIST_CAP, 32'h0);
      send_item(pol_pkg::KIND_INSERT, LIST_CAP, 32'hFFFF_FFFF);
      send_item(pol_pkg::KIND_INSERT, LIST_CAP + 1, $urandom);
      while (list_elems.size() > 0)
         send_item(pol_pkg::KIND_DELETE, $urandom_range(1, list_elems.size()), $urandom);
      drain_list_ops();
   endtask

   task automatic test_random_ops(input int unsigned count);
      int unsigned               len;
      int unsigned               pos;
      int unsigned               roll;
      bit                        grow;
      pol_pkg::kind_type         kind;
      logic [pol_pkg::VAL_W-1:0] val;
      for (int k = 0; k < count; k++) begin
         grow  = ((k / 200) % 2) == 0;
         quiet = (k >= 500 && k < 650);
         if (k == count / 2) drain_list_ops();
         len  = list_elems.size();
         roll = $urandom_range(0, 99);
         if (grow)
            kind = roll < 40 ? pol_pkg::KIND_INSERT : roll < 55 ? pol_pkg::KIND_DELETE :
                   roll < 75 ? pol_pkg::KIND_GET : pol_pkg::KIND_LOCATE;
         else
            kind = roll < 10 ? pol_pkg::KIND_INSERT : roll < 50 ? pol_pkg::KIND_DELETE :
                   roll < 72 ? pol_pkg::KIND_GET : pol_pkg::KIND_LOCATE;
         roll = $urandom_range(0, 99);
         if (kind == pol_pkg::KIND_LOCATE && len > 0 && roll < 50)
            val = list_elems[$urandom_range(0, len - 1)];
         else if (roll < 80)
            val = $urandom_range(0, 7);
         else if (roll < 85)
            val = 32'hFFFF_FFFF;
         else
            val = $urandom;
         if ($urandom_range(0, 99) < 15)
            pos = $urandom_range(0, 127);
         else if (kind == pol_pkg::KIND_INSERT)
            pos = $urandom_range(1, len + 1);
         else
            pos = len > 0 ? $urandom_range(1, len) : $urandom_range(0, 1);
         send_item(kind, pos, val);
      end
      quiet = 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_list();
      test_edit_sequence();
      test_full_list();
      test_random_ops(1700);
      drain_list_ops();
      repeat (LIST_CAP + 8) @(posedge clock);
      if (fail_count == 0 && op_results_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire

@@ positional_ordered_list.f @@
hdl/pol_pkg.sv
hdl/pol_store.sv
hdl/positional_ordered_list.sv
sim/tb_top.sv
